// ----- src/qpr_pkg.sv -----
// ----------------------------------------------------------------------------
// qpr_pkg: shared definitions of the quaternion point rotator
// Default field widths, the register-port geometry and the register indexes.
// ----------------------------------------------------------------------------
package qpr_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int QUAT_WIDTH_DEFAULT  = 16;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   typedef enum logic [1:0] {
      REG_QUAT_W = 2'd0,
      REG_QUAT_X = 2'd1,
      REG_QUAT_Y = 2'd2,
      REG_QUAT_Z = 2'd3
   } csr_index_type;

endpackage

// ----- src/qpr_csr.sv -----
// ----------------------------------------------------------------------------
// qpr_csr: quaternion register file
// Holds the four quaternion components behind an APB-style register port.
// ----------------------------------------------------------------------------
module qpr_csr #(
   parameter int QUAT_WIDTH = qpr_pkg::QUAT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [qpr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [qpr_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [qpr_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic signed [QUAT_WIDTH-1:0]        quat_w,
   output logic signed [QUAT_WIDTH-1:0]        quat_x,
   output logic signed [QUAT_WIDTH-1:0]        quat_y,
   output logic signed [QUAT_WIDTH-1:0]        quat_z
);

   localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);

   logic [QUAT_WIDTH-1:0] quat_w_ff;
   logic [QUAT_WIDTH-1:0] quat_x_ff;
   logic [QUAT_WIDTH-1:0] quat_y_ff;
   logic [QUAT_WIDTH-1:0] quat_z_ff;
   logic [QUAT_WIDTH-1:0] read_value;
   logic                  write_en;
   qpr_pkg::csr_index_type index;

   assign write_en = psel && penable && pwrite;
   assign index    = qpr_pkg::csr_index_type'(paddr[qpr_pkg::CSR_ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else if (write_en) begin
         unique case (index)
            qpr_pkg::REG_QUAT_W: quat_w_ff <= pwdata[QUAT_WIDTH-1:0];
            qpr_pkg::REG_QUAT_X: quat_x_ff <= pwdata[QUAT_WIDTH-1:0];
            qpr_pkg::REG_QUAT_Y: quat_y_ff <= pwdata[QUAT_WIDTH-1:0];
            qpr_pkg::REG_QUAT_Z: quat_z_ff <= pwdata[QUAT_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         qpr_pkg::REG_QUAT_W: read_value = quat_w_ff;
         qpr_pkg::REG_QUAT_X: read_value = quat_x_ff;
         qpr_pkg::REG_QUAT_Y: read_value = quat_y_ff;
         qpr_pkg::REG_QUAT_Z: read_value = quat_z_ff;
      endcase
   end

   assign prdata = qpr_pkg::CSR_DATA_WIDTH'(read_value);
   assign quat_w = quat_w_ff;
   assign quat_x = quat_x_ff;
   assign quat_y = quat_y_ff;
   assign quat_z = quat_z_ff;

endmodule

// ----- src/quaternion_point_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_point_rotate: streaming rotation of 3D points by a quaternion
// Forms q * (0,p) * conj(q) in fixed point and returns the saturated vector
// part together with an overflow flag.
// ----------------------------------------------------------------------------
//  Channel  Role             Beat contents
//  req_     stream in        tdata: pos_x, pos_y, pos_z
//  rsp_     stream out       tdata: rot_x, rot_y, rot_z; tuser: overflow
//  csr_     APB-style slave  quat_w, quat_x, quat_y, quat_z at 0x0, 0x4, 0x8, 0xC
//
// One beat is accepted every cycle unless the output stalls; each beat passes
// through four register stages: two multiplier ranks, each followed by a rank
// of adders with rounding. Reset clears the stage valid bits and loads the
// identity quaternion. A stalled output holds each stage only while the next
// one is full, so empty stages keep filling and no beat is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_point_rotate #(
   parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUAT_WIDTH  = qpr_pkg::QUAT_WIDTH_DEFAULT,
   localparam int DATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [qpr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [qpr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [qpr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [DATA_WIDTH-1:0]               req_tdata,  // pos_x, pos_y, pos_z
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [DATA_WIDTH-1:0]               rsp_tdata,  // rot_x, rot_y, rot_z
   output logic                                rsp_tuser   // overflow
);

   localparam int QFRAC = QUAT_WIDTH - 2;
   localparam int P1W   = COORD_WIDTH + QUAT_WIDTH;
   localparam int S1W   = P1W + 2;
   localparam int TW    = S1W - QFRAC;
   localparam int P2W   = TW + QUAT_WIDTH;
   localparam int S2W   = P2W + 2;
   localparam int RW    = S2W - QFRAC;
   localparam int AX    = 0;
   localparam int AY    = 1;
   localparam int AZ    = 2;

   localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (QFRAC - 1);
   localparam logic signed [S2W-1:0] HALF2 = S2W'(1) << (QFRAC - 1);
   localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   localparam int QW = int'(qpr_pkg::REG_QUAT_W);
   localparam int QX = int'(qpr_pkg::REG_QUAT_X);
   localparam int QY = int'(qpr_pkg::REG_QUAT_Y);
   localparam int QZ = int'(qpr_pkg::REG_QUAT_Z);

   logic signed [QUAT_WIDTH-1:0]  quat [4];
   logic signed [COORD_WIDTH-1:0] pos  [3];

   logic signed [P1W-1:0]         prod1_in [4][3];
   logic signed [P1W-1:0]         prod1_ff [4][3];
   logic signed [S1W-1:0]         sum1     [4];
   logic signed [TW-1:0]          t_in     [4];
   logic signed [TW-1:0]          t_ff     [4];
   logic signed [P2W-1:0]         prod2_in [3][4];
   logic signed [P2W-1:0]         prod2_ff [3][4];
   logic signed [S2W-1:0]         sum2     [3];
   logic signed [RW-1:0]          rnd      [3];
   logic signed [COORD_WIDTH-1:0] rot_in   [3];
   logic signed [COORD_WIDTH-1:0] rot_ff   [3];
   logic [2:0]                    clip;
   logic                          overflow_in;
   logic                          overflow_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   qpr_csr #(
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .quat_w  (quat[QW]),
      .quat_x  (quat[QX]),
      .quat_y  (quat[QY]),
      .quat_z  (quat[QZ])
   );

   assign csr_pready = 1'b1;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pos[j] = req_tdata[j*COORD_WIDTH +: COORD_WIDTH];
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod1_in[i][j] = P1W'(quat[i]) * P1W'(pos[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod1_ff <= prod1_in;
      end
   end

   always_comb begin
      sum1[0] = -S1W'(prod1_ff[QX][AX]) - S1W'(prod1_ff[QY][AY])
                - S1W'(prod1_ff[QZ][AZ]) + HALF1;
      sum1[1] =  S1W'(prod1_ff[QW][AX]) + S1W'(prod1_ff[QY][AZ])
                - S1W'(prod1_ff[QZ][AY]) + HALF1;
      sum1[2] =  S1W'(prod1_ff[QW][AY]) - S1W'(prod1_ff[QX][AZ])
                + S1W'(prod1_ff[QZ][AX]) + HALF1;
      sum1[3] =  S1W'(prod1_ff[QW][AZ]) + S1W'(prod1_ff[QX][AY])
                - S1W'(prod1_ff[QY][AX]) + HALF1;
      for (int k = 0; k < 4; k++) begin
         t_in[k] = sum1[k][S1W-1:QFRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         t_ff <= t_in;
      end
   end

   always_comb begin
      prod2_in[0][0] = P2W'(t_ff[0]) * P2W'(quat[QX]);
      prod2_in[0][1] = P2W'(t_ff[1]) * P2W'(quat[QW]);
      prod2_in[0][2] = P2W'(t_ff[2]) * P2W'(quat[QZ]);
      prod2_in[0][3] = P2W'(t_ff[3]) * P2W'(quat[QY]);
      prod2_in[1][0] = P2W'(t_ff[0]) * P2W'(quat[QY]);
      prod2_in[1][1] = P2W'(t_ff[1]) * P2W'(quat[QZ]);
      prod2_in[1][2] = P2W'(t_ff[2]) * P2W'(quat[QW]);
      prod2_in[1][3] = P2W'(t_ff[3]) * P2W'(quat[QX]);
      prod2_in[2][0] = P2W'(t_ff[0]) * P2W'(quat[QZ]);
      prod2_in[2][1] = P2W'(t_ff[1]) * P2W'(quat[QY]);
      prod2_in[2][2] = P2W'(t_ff[2]) * P2W'(quat[QX]);
      prod2_in[2][3] = P2W'(t_ff[3]) * P2W'(quat[QW]);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         prod2_ff <= prod2_in;
      end
   end

   always_comb begin
      sum2[0] = -S2W'(prod2_ff[0][0]) + S2W'(prod2_ff[0][1])
                - S2W'(prod2_ff[0][2]) + S2W'(prod2_ff[0][3]) + HALF2;
      sum2[1] = -S2W'(prod2_ff[1][0]) + S2W'(prod2_ff[1][1])
                + S2W'(prod2_ff[1][2]) - S2W'(prod2_ff[1][3]) + HALF2;
      sum2[2] = -S2W'(prod2_ff[2][0]) - S2W'(prod2_ff[2][1])
                + S2W'(prod2_ff[2][2]) + S2W'(prod2_ff[2][3]) + HALF2;
      for (int r = 0; r < 3; r++) begin
         rnd[r]  = sum2[r][S2W-1:QFRAC];
         clip[r] = !((&rnd[r][RW-1:COORD_WIDTH-1]) || !(|rnd[r][RW-1:COORD_WIDTH-1]));
         if (clip[r]) begin
            rot_in[r] = rnd[r][RW-1] ? SAT_MIN : SAT_MAX;
         end else begin
            rot_in[r] = rnd[r][COORD_WIDTH-1:0];
         end
      end
      overflow_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rot_ff      <= rot_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = DATA_WIDTH'({rot_ff[2], rot_ff[1], rot_ff[0]});
   assign rsp_tuser  = overflow_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rot_ff[0] == SAT_MAX || rot_ff[0] == SAT_MIN ||
          rot_ff[1] == SAT_MAX || rot_ff[1] == SAT_MIN ||
          rot_ff[2] == SAT_MAX || rot_ff[2] == SAT_MIN))
      else $error("overflow flagged without a saturated coordinate");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted beat did not enter the first stage");

   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && rsp_tready) |=> rsp_tvalid)
      else $error("beat in the last product stage did not reach the output");
`endif

endmodule
